@@ rtl/lbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// lbsm_pkg: shared types and constants of the boolean stack machine
// Stack depth, I/O address map, word codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbsm_pkg;

  localparam int unsigned STACK_DEPTH = 16;

  // I/O address map: inputs at the bottom, outputs one page up
  localparam logic [7:0] ADDR_IN_LAST   = 8'h07;
  localparam logic [7:0] ADDR_OUT_FIRST = 8'h10;
  localparam logic [7:0] ADDR_OUT_LAST  = 8'h17;

  localparam int unsigned CFG_IDX_W = 4;

  typedef enum logic [1:0] {
    ACT_BEGIN  = 2'd0,
    ACT_BYTE   = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_END      = 4'd0,
    CFG_LOAD     = 4'd1,
    CFG_LOAD_NOT = 4'd2,
    CFG_AND      = 4'd3,
    CFG_AND_NOT  = 4'd4,
    CFG_OR       = 4'd5,
    CFG_OR_NOT   = 4'd6,
    CFG_OUT      = 4'd7
  } cfg_idx_t;

  // Control for one stack cell
  typedef struct packed {
    logic clear;  // drop the occupied flag
    logic shift;  // take the neighbour's bit and flag (push)
    logic load;   // take the neighbour's bit and flag without a push (head only)
  } cell_ctl_t;

endpackage : lbsm_pkg

`default_nettype wire

@@ rtl/ladder_boolean_stack_machine.sv @@
// ----------------------------------------------------------------------------
// ladder_boolean_stack_machine: instruction-list boolean stack machine
// Runs a ladder program one byte per word on a row of stack cells and
// reports at most one status word with the output image per program.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                               | tuser
//  --------+-----------+-------------------------------------+------------------
//  in_     | slave     | [7:0] input_image, [15:8] prog_byte | [1:0] action
//  out_    | master    | [7:0] output_image                  | [1:0] status
//  cfg_    | write     | cfg_wdata = opcode byte value       | cfg_addr = index
//
//  One input word is taken every cycle while in_tready is high; each word
//  updates the stack cells, the I/O image and the sequencing flags in that
//  same cycle. A result word is registered into the output register,
//  or into the skid register behind it, which keeps the input flowing
//  while a result waits; in_tready drops only when both are full.
//  Reset (synchronous, active low) empties the stack cells at once: no
//  clearing pass, so the first word can be taken right after reset.
//
`timescale 1ns / 1ps
`default_nettype none

module ladder_boolean_stack_machine (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [15:0]                    in_tdata,  // [7:0] input_image, [15:8] prog_byte
  input  wire logic [1:0]                     in_tuser,  // [1:0] action
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [7:0]                          out_tdata, // [7:0] output_image
  output logic [1:0]                          out_tuser, // [1:0] status
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [lbsm_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [7:0]                     cfg_wdata
);
  import lbsm_pkg::*;

  // decoded operation kinds held between opcode and address byte
  typedef enum logic [2:0] {
    K_LD   = 3'd0,
    K_LDN  = 3'd1,
    K_AND  = 3'd2,
    K_ANDN = 3'd3,
    K_OR   = 3'd4,
    K_ORN  = 3'd5,
    K_OUT  = 3'd6,
    K_BAD  = 3'd7
  } op_t;

  // ---------------------------------------------------------------- config
  logic [7:0] code_end_r, code_load_r, code_load_not_r, code_and_r;
  logic [7:0] code_and_not_r, code_or_r, code_or_not_r, code_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_end_r      <= 8'd0;
      code_load_r     <= 8'd1;
      code_load_not_r <= 8'd2;
      code_and_r      <= 8'd3;
      code_and_not_r  <= 8'd4;
      code_or_r       <= 8'd5;
      code_or_not_r   <= 8'd6;
      code_out_r      <= 8'd7;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_END:      code_end_r      <= cfg_wdata;
        CFG_LOAD:     code_load_r     <= cfg_wdata;
        CFG_LOAD_NOT: code_load_not_r <= cfg_wdata;
        CFG_AND:      code_and_r      <= cfg_wdata;
        CFG_AND_NOT:  code_and_not_r  <= cfg_wdata;
        CFG_OR:       code_or_r       <= cfg_wdata;
        CFG_OR_NOT:   code_or_not_r   <= cfg_wdata;
        CFG_OUT:      code_out_r      <= cfg_wdata;
        default:      ; // indexes past the register list are dropped
      endcase
    end
  end

  // ------------------------------------------------------------ word fields
  logic       in_fire;
  logic [7:0] in_image;
  logic [7:0] prog_byte;

  assign in_fire   = in_tvalid && in_tready;
  assign in_image  = in_tdata[7:0];
  assign prog_byte = in_tdata[15:8];

  // first match wins, in register order
  function automatic op_t decode_op(input logic [7:0] b,
                                    input logic [7:0] c_ld, input logic [7:0] c_ldn,
                                    input logic [7:0] c_and, input logic [7:0] c_andn,
                                    input logic [7:0] c_or, input logic [7:0] c_orn,
                                    input logic [7:0] c_out);
    op_t k;
    if      (b == c_ld)   k = K_LD;
    else if (b == c_ldn)  k = K_LDN;
    else if (b == c_and)  k = K_AND;
    else if (b == c_andn) k = K_ANDN;
    else if (b == c_or)   k = K_OR;
    else if (b == c_orn)  k = K_ORN;
    else if (b == c_out)  k = K_OUT;
    else                  k = K_BAD;
    return k;
  endfunction

  // --------------------------------------------------------- program state
  logic [7:0] latched_r, latched_nxt;
  logic [7:0] out_bits_r, out_bits_nxt;
  logic       expect_addr_r, expect_addr_nxt;
  op_t        pending_r, pending_nxt;
  logic       halted_r, halted_nxt;

  // ------------------------------------------------------------ stack cells
  logic [STACK_DEPTH-1:0] cell_bit;
  logic [STACK_DEPTH-1:0] cell_occ;
  cell_ctl_t              head_ctl;
  cell_ctl_t              tail_ctl;
  logic                   head_bit;  // value entering the head cell

  // head cell sits at index 0 and is the top of the stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      lbsm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (head_ctl),
        .prev_bit (head_bit),
        .prev_occ (1'b1),
        .bit_q    (cell_bit[i]),
        .occ_q    (cell_occ[i])
      );
    end else begin : g_body
      lbsm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (tail_ctl),
        .prev_bit (cell_bit[i-1]),
        .prev_occ (cell_occ[i-1]),
        .bit_q    (cell_bit[i]),
        .occ_q    (cell_occ[i])
      );
    end
  end

  // -------------------------------------------------------- execute a word
  logic       has_top;
  logic       stack_full;
  logic       io_val;
  logic       is_in_addr;
  logic       is_out_addr;
  logic       res_valid;
  status_t    res_status;
  logic       do_clear, do_push, do_load;

  assign has_top     = cell_occ[0];
  assign stack_full  = cell_occ[STACK_DEPTH-1];
  assign is_in_addr  = (prog_byte <= ADDR_IN_LAST);
  assign is_out_addr = (prog_byte >= ADDR_OUT_FIRST) && (prog_byte <= ADDR_OUT_LAST);

  // unmapped addresses read as zero
  always_comb begin
    if (is_in_addr) begin
      io_val = latched_r[prog_byte[2:0]];
    end else if (is_out_addr) begin
      io_val = out_bits_r[prog_byte[2:0]];
    end else begin
      io_val = 1'b0;
    end
  end

  always_comb begin
    latched_nxt     = latched_r;
    out_bits_nxt    = out_bits_r;
    expect_addr_nxt = expect_addr_r;
    pending_nxt     = pending_r;
    halted_nxt      = halted_r;
    res_valid       = 1'b0;
    res_status      = ST_OK;
    do_clear        = 1'b0;
    do_push         = 1'b0;
    do_load         = 1'b0;
    head_bit        = io_val;

    if (in_fire) begin
      case (in_tuser)
        ACT_BEGIN: begin
          // abandon any running program and start afresh; outputs are kept
          latched_nxt     = in_image;
          do_clear        = 1'b1;
          expect_addr_nxt = 1'b0;
          pending_nxt     = K_LD;
          halted_nxt      = 1'b0;
        end
        ACT_FINISH: begin
          if (!halted_r) begin
            res_valid  = 1'b1;
            res_status = expect_addr_r ? ST_TRUNC : ST_OK;
          end
        end
        ACT_BYTE: begin
          if (!halted_r && !expect_addr_r) begin
            if (prog_byte == code_end_r) begin
              res_valid  = 1'b1;
              res_status = ST_OK;
            end else begin
              pending_nxt     = decode_op(prog_byte, code_load_r, code_load_not_r,
                                          code_and_r, code_and_not_r, code_or_r,
                                          code_or_not_r, code_out_r);
              expect_addr_nxt = 1'b1;
            end
          end else if (!halted_r) begin
            expect_addr_nxt = 1'b0;
            case (pending_r) inside
              K_LD, K_LDN: begin
                if (stack_full) begin
                  res_valid  = 1'b1;
                  res_status = ST_OVERFLOW;
                end else begin
                  head_bit = (pending_r == K_LD) ? io_val : ~io_val;
                  do_push  = 1'b1;
                end
              end
              K_AND: begin
                head_bit = cell_bit[0] & io_val;
                do_load  = has_top;
              end
              K_ANDN: begin
                head_bit = cell_bit[0] & ~io_val;
                do_load  = has_top;
              end
              K_OR: begin
                head_bit = cell_bit[0] | io_val;
                do_load  = has_top;
              end
              K_ORN: begin
                head_bit = cell_bit[0] | ~io_val;
                do_load  = has_top;
              end
              K_OUT: begin
                // writes to inputs or unmapped addresses fall away
                if (has_top && is_out_addr) begin
                  out_bits_nxt[prog_byte[2:0]] = cell_bit[0];
                end
              end
              default: begin
                res_valid  = 1'b1;
                res_status = ST_UNKNOWN;
              end
            endcase
          end
        end
        default: ; // unused action code: drop the word
      endcase

      // any result ends the program
      if (res_valid) begin
        halted_nxt      = 1'b1;
        expect_addr_nxt = 1'b0;
      end
    end
  end

  assign head_ctl = '{clear: do_clear, shift: do_push, load: do_load};
  assign tail_ctl = '{clear: do_clear, shift: do_push, load: 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r     <= 8'd0;
      out_bits_r    <= 8'd0;
      expect_addr_r <= 1'b0;
      pending_r     <= K_LD;
      halted_r      <= 1'b1;
    end else begin
      latched_r     <= latched_nxt;
      out_bits_r    <= out_bits_nxt;
      expect_addr_r <= expect_addr_nxt;
      pending_r     <= pending_nxt;
      halted_r      <= halted_nxt;
    end
  end

  // ------------------------------------------------- output and skid stage
  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  logic [7:0] out_image_r, out_image_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  status_t    skid_status_r, skid_status_nxt;
  logic [7:0] skid_image_r, skid_image_nxt;
  logic       out_take;

  // the output register can load when empty or being drained
  assign out_take = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_image_nxt   = out_image_r;
    skid_valid_nxt  = skid_valid_r;
    skid_status_nxt = skid_status_r;
    skid_image_nxt  = skid_image_r;
    if (out_take) begin
      if (skid_valid_r) begin
        // advance the older word first; no new result while the skid is full
        out_valid_nxt  = 1'b1;
        out_status_nxt = skid_status_r;
        out_image_nxt  = skid_image_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = res_valid;
        out_status_nxt = res_status;
        out_image_nxt  = out_bits_r;
      end
    end else if (res_valid) begin
      // hold the new result aside while the output stalls
      skid_valid_nxt  = 1'b1;
      skid_status_nxt = res_status;
      skid_image_nxt  = out_bits_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_image_r   <= out_image_nxt;
    skid_status_r <= skid_status_nxt;
    skid_image_r  <= skid_image_nxt;
  end

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_image_r;
  assign out_tuser  = out_status_r;

endmodule : ladder_boolean_stack_machine

`default_nettype wire

@@ rtl/lbsm_cell.sv @@
// ----------------------------------------------------------------------------
// lbsm_cell: one entry of the bit stack
// Holds a stack bit and its occupied flag; takes both from the upstream
// neighbour on a push, or on a head rewrite.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbsm_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lbsm_pkg::cell_ctl_t ctl,
  input  wire logic              prev_bit,
  input  wire logic              prev_occ,
  output logic                   bit_q,
  output logic                   occ_q
);
  import lbsm_pkg::*;

  logic bit_r;
  logic occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (ctl.clear) begin
      occ_r <= 1'b0;
    end else if (ctl.shift || ctl.load) begin
      occ_r <= prev_occ;
    end
  end

  // payload: no reset, an empty cell is never read
  always_ff @(posedge clk) begin
    if (ctl.shift || ctl.load) begin
      bit_r <= prev_bit;
    end
  end

  assign bit_q = bit_r;
  assign occ_q = occ_r;

endmodule : lbsm_cell

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ladder boolean stack machine
// Feeds ladder programs word by word with random idling on both channels,
// predicts each status/output-image report and checks it field by field.
// Opcode values are reprogrammed between phases, including aliased codes.
// ----------------------------------------------------------------------------

module tb;
  import lbsm_pkg::*;

  // opcode byte values straight out of reset
  localparam logic [7:0] OPC_END  = 8'd0;
  localparam logic [7:0] OPC_LD   = 8'd1;
  localparam logic [7:0] OPC_LDN  = 8'd2;
  localparam logic [7:0] OPC_AND  = 8'd3;
  localparam logic [7:0] OPC_ANDN = 8'd4;
  localparam logic [7:0] OPC_OR   = 8'd5;
  localparam logic [7:0] OPC_ORN  = 8'd6;
  localparam logic [7:0] OPC_OUT  = 8'd7;

  localparam logic [1:0] ACT_RESERVED = 2'd3;       // action code with no meaning
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'hF; // no register behind it

  localparam int PHASE_WORDS  = 400;
  localparam int CHOKE_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int STK_IDX_W = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    OP_LD, OP_LDN, OP_AND, OP_ANDN, OP_OR, OP_ORN, OP_OUT, OP_BAD
  } op_kind_t;

  typedef enum int {
    CODES_SCRAMBLED, CODES_EXTREME, CODES_ALIASED, CODES_RESET
  } code_set_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] image;
  } report_t;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] img;
    logic [7:0] pb;
    logic       typed;   // expected report written into the row
    status_t    st;
    logic [7:0] oimg;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata  = '0;  // [7:0] input_image, [15:8] prog_byte
  logic [1:0]           in_tuser  = '0;  // [1:0] action
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // [7:0] output_image
  logic [1:0]           out_tuser;       // [1:0] status
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = '0;
  logic [7:0]           cfg_wdata = '0;

  ladder_boolean_stack_machine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Machine image kept by the bench: opcode table, bit stack, I/O and flags
  // --------------------------------------------------------------------------
  logic [7:0]             code_val [8];
  logic [STACK_DEPTH-1:0] stk;
  int                     depth;
  logic [7:0]             latched;
  logic [7:0]             outs;
  bit                     want_addr;
  bit                     idle;
  op_kind_t               pend;

  report_t due_reports[$];   // reports predicted but not yet seen
  int      fail_count = 0;
  int      words_fed = 0;
  bit      calm = 1'b0;      // both sides stop idling while set
  bit      choke = 1'b0;     // asks the receiver for one long hold-off
  bit      word_made;        // last accepted word produced a report

  // opcode value held for one register of the table
  function automatic logic [7:0] code_of(input cfg_idx_t i);
    return code_val[i[2:0]];
  endfunction

  function automatic logic io_bit(input logic [7:0] a);
    if (a <= ADDR_IN_LAST) return latched[a[2:0]];
    if (a >= ADDR_OUT_FIRST && a <= ADDR_OUT_LAST) return outs[a[2:0]];
    return 1'b0;  // unmapped addresses read low
  endfunction

  // first match wins when codes are aliased
  function automatic op_kind_t decode_op(input logic [7:0] b);
    if (b == code_of(CFG_LOAD))     return OP_LD;
    if (b == code_of(CFG_LOAD_NOT)) return OP_LDN;
    if (b == code_of(CFG_AND))      return OP_AND;
    if (b == code_of(CFG_AND_NOT))  return OP_ANDN;
    if (b == code_of(CFG_OR))       return OP_OR;
    if (b == code_of(CFG_OR_NOT))   return OP_ORN;
    if (b == code_of(CFG_OUT))      return OP_OUT;
    return OP_BAD;
  endfunction

  function automatic bit close_program(input status_t s, output report_t r);
    r.status  = s;
    r.image   = outs;
    idle      = 1'b1;
    want_addr = 1'b0;
    return 1'b1;
  endfunction

  // Advance the machine image by one word; returns 1 when a report is due.
  function automatic bit exec_word(input logic [1:0] act, input logic [7:0] img,
                                   input logic [7:0] pb, output report_t r);
    logic                 val;
    logic                 top;
    bit                   has;
    logic [STK_IDX_W-1:0] ti;
    r = '0;
    if (act == ACT_BEGIN) begin
      latched   = img;
      stk       = '0;
      depth     = 0;
      want_addr = 1'b0;
      pend      = OP_LD;
      idle      = 1'b0;
      return 1'b0;
    end
    if (idle) return 1'b0;
    if (act == ACT_FINISH) return close_program(want_addr ? ST_TRUNC : ST_OK, r);
    if (act != ACT_BYTE) return 1'b0;
    if (!want_addr) begin
      if (pb == code_of(CFG_END)) return close_program(ST_OK, r);
      pend      = decode_op(pb);
      want_addr = 1'b1;
      return 1'b0;
    end
    want_addr = 1'b0;
    val = io_bit(pb);
    has = (depth != 0);
    ti  = STK_IDX_W'(depth - 1);
    top = has ? stk[ti] : 1'b0;
    case (pend)
      OP_LD, OP_LDN: begin
        if (depth >= STACK_DEPTH) return close_program(ST_OVERFLOW, r);
        stk[STK_IDX_W'(depth)] = (pend == OP_LD) ? val : ~val;
        depth++;
      end
      OP_AND:  if (has) stk[ti] = top & val;
      OP_ANDN: if (has) stk[ti] = top & ~val;
      OP_OR:   if (has) stk[ti] = top | val;
      OP_ORN:  if (has) stk[ti] = top | ~val;
      OP_OUT: begin
        // inputs and unmapped addresses swallow the write
        if (has && pb >= ADDR_OUT_FIRST && pb <= ADDR_OUT_LAST) outs[pb[2:0]] = top;
      end
      default: return close_program(ST_UNKNOWN, r);
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // mostly back-to-back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_opcode(input bit stacky);
    int r;
    r = $urandom_range(0, 99);
    if (stacky && r < 80) return code_val[3'($urandom_range(CFG_LOAD, CFG_LOAD_NOT))];
    if (r < 90) return code_val[3'($urandom_range(CFG_LOAD, CFG_OUT))];
    if (r < 93) return code_of(CFG_END);
    return 8'($urandom);  // mostly unknown opcodes
  endfunction

  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(0, ADDR_IN_LAST));
    if (r < 80) return 8'($urandom_range(ADDR_OUT_FIRST, ADDR_OUT_LAST));
    return 8'($urandom);
  endfunction

  // Offer one word, hold it until taken, then predict what it causes.
  // Valid stays high into the next word when no gap follows.
  task automatic send_word(input logic [1:0] act, input logic [7:0] img,
                           input logic [7:0] pb);
    int      gap;
    report_t rep;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pb, img};
    in_tuser  <= act;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    if (act == ACT_BEGIN || !idle) words_fed++;
    word_made = exec_word(act, img, pb, rep);
    if (word_made) due_reports.push_back(rep);
  endtask

  // Drop valid and wait until every predicted report has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    if (idx <= CFG_OUT) code_val[idx[2:0]] = v;
  endtask

  task automatic program_codes(input code_set_t style);
    logic [7:0] v [8];
    bit         clash;
    case (style)
      CODES_SCRAMBLED: begin
        // eight distinct random values
        for (int k = 0; k < 8; k++) begin
          do begin
            v[k]  = 8'($urandom);
            clash = 1'b0;
            for (int j = 0; j < k; j++) if (v[j] == v[k]) clash = 1'b1;
          end while (clash);
        end
      end
      CODES_EXTREME: v = '{8'hFF, 8'h00, 8'hFE, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55};
      // LDN hides behind LD, ANDN behind AND, OR_NOT behind END
      CODES_ALIASED: v = '{8'h40, 8'h41, 8'h41, 8'h42, 8'h42, 8'h43, 8'h40, 8'h44};
      default:       v = '{OPC_END, OPC_LD, OPC_LDN, OPC_AND, OPC_ANDN, OPC_OR,
                           OPC_ORN, OPC_OUT};
    endcase
    for (int k = 0; k < 8; k++) write_reg(k[CFG_IDX_W-1:0], v[k]);
    write_reg(CFG_IDX_SPARE, (style == CODES_EXTREME) ? 8'hFF : 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  // One program: begin, random instruction pairs, then one of several endings.
  task automatic run_program();
    int n;
    int ending;
    bit stacky;
    if ($urandom_range(0, 7) == 0) calm = ~calm;
    stacky = ($urandom_range(0, 5) == 0);  // deep push runs reach overflow
    n = stacky ? $urandom_range(14, 22) : $urandom_range(0, 10);
    send_word(ACT_BEGIN, 8'($urandom), 8'($urandom));
    repeat (n) begin
      send_word(ACT_BYTE, 8'($urandom), pick_opcode(stacky));
      send_word(ACT_BYTE, 8'($urandom), pick_addr());
    end
    ending = $urandom_range(0, 9);
    case (ending)
      0, 1, 2, 3, 4: send_word(ACT_BYTE, 8'($urandom), code_of(CFG_END));
      5, 6:          send_word(ACT_FINISH, 8'($urandom), 8'($urandom));
      7: begin
        // opcode with its address byte missing
        send_word(ACT_BYTE, 8'($urandom), pick_opcode(1'b0));
        send_word(ACT_FINISH, 8'($urandom), 8'($urandom));
      end
      8: ;  // abandon: the next begin restarts without a report
      default: begin
        send_word(ACT_FINISH, 8'($urandom), 8'($urandom));
        send_word(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random hold-offs, one long choke on request, check each report
  // --------------------------------------------------------------------------
  task automatic check_report(input logic [1:0] st, input logic [7:0] img);
    report_t want;
    if (due_reports.size() == 0) begin
      $error("unexpected report: status %0d output_image %02h", st, img);
      fail_count++;
      return;
    end
    want = due_reports.pop_front();
    if (st !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, st);
      fail_count++;
    end
    if (img !== want.image) begin
      $error("output_image: expected %02h, got %02h", want.image, img);
      fail_count++;
    end
  endtask

  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (choke) begin
        // hold off long enough for the block to back up into its input
        out_tready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choke = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      check_report(out_tuser, out_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    script_row_t script [25];
    int          start;
    bit          squeezed;

    // machine image as it comes out of reset
    code_val  = '{OPC_END, OPC_LD, OPC_LDN, OPC_AND, OPC_ANDN, OPC_OR, OPC_ORN, OPC_OUT};
    stk       = '0;
    depth     = 0;
    latched   = '0;
    outs      = '0;
    want_addr = 1'b0;
    idle      = 1'b1;
    pend      = OP_LD;
    squeezed  = 1'b0;

    script = '{
      // finish and a reserved action while halted: both ignored
      '{ACT_FINISH,   8'h00, 8'h00,           1'b0, ST_OK,      8'h00},
      '{ACT_RESERVED, 8'hFF, 8'hFF,           1'b0, ST_OK,      8'h00},
      // END straight after begin
      '{ACT_BEGIN,    8'hFF, 8'h00,           1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, OPC_END,         1'b1, ST_OK,      8'h00},
      // load input 0, drive output 7, ANDN unmapped, ORN output 0,
      // write to an input (ignored), finish cleanly
      '{ACT_BEGIN,    8'h01, 8'h00,           1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, OPC_LD,          1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, 8'h00,           1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, OPC_OUT,         1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, ADDR_OUT_LAST,   1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, OPC_ANDN,        1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, 8'hFF,           1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, OPC_ORN,         1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, ADDR_OUT_FIRST,  1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, OPC_OUT,         1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, ADDR_IN_LAST,    1'b0, ST_OK,      8'h00},
      '{ACT_FINISH,   8'h00, 8'h00,           1'b1, ST_OK,      8'h80},
      // OR on an empty stack, then an unknown opcode cut short by finish
      '{ACT_BEGIN,    8'h00, 8'h00,           1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, OPC_OR,          1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, ADDR_OUT_LAST,   1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, 8'hEE,           1'b0, ST_OK,      8'h00},
      '{ACT_FINISH,   8'h00, 8'h00,           1'b1, ST_TRUNC,   8'h80},
      // unknown opcode reported at its address byte
      '{ACT_BEGIN,    8'h00, 8'h00,           1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, 8'hEE,           1'b0, ST_OK,      8'h00},
      '{ACT_BYTE,     8'h00, ADDR_OUT_FIRST,  1'b1, ST_UNKNOWN, 8'h80},
      // program byte after the halt: ignored
      '{ACT_BYTE,     8'h00, OPC_LDN,         1'b0, ST_OK,      8'h00}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; rows with a written report override the prediction
    foreach (script[i]) begin
      send_word(script[i].act, script[i].img, script[i].pb);
      if (script[i].typed) begin
        if (word_made) void'(due_reports.pop_back());
        due_reports.push_back('{script[i].st, script[i].oimg});
      end
    end

    // random phases, each under a different opcode table
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      program_codes(code_set_t'(ph));
      start = words_fed;
      while (words_fed - start < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray words, mostly landing on a halted machine
          repeat ($urandom_range(1, 3))
            send_word(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom));
        end
        run_program();
        if (ph == 0 && !squeezed && words_fed - start > PHASE_WORDS / 2) begin
          // keep short reporting programs coming while the receiver chokes
          squeezed = 1'b1;
          choke    = 1'b1;
          repeat (12) begin
            send_word(ACT_BEGIN, 8'($urandom), 8'($urandom));
            send_word(ACT_BYTE, 8'($urandom), code_of(CFG_END));
          end
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
